/* hw/rtl/cip_pkg.sv */
// ----------------------------------------------------------------------------
// cip_pkg - complex integer power shared definitions
// Number format constants, saturation limits and the beat structs of the
// command and result ports.
// ----------------------------------------------------------------------------
package cip_pkg;

    // Fixed point format: signed 64 bits with FRAC_BITS fraction bits
    localparam int FRAC_BITS = 56;
    localparam int WORD_W    = 64;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int HALF_W    = WORD_W / 2;

    // Exponent bits honored (low bits of the 8-bit exponent)
    localparam int EXP_BITS  = 8;
    localparam int EXP_W     = 8;

    localparam logic [WORD_W-1:0] Q_ONE   = WORD_W'(1) << FRAC_BITS;
    localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Command beat
    typedef struct packed {
        logic signed [WORD_W-1:0] base_re;
        logic signed [WORD_W-1:0] base_im;
        logic signed [EXP_W-1:0]  exponent;
    } cip_in_t;

    // Result beat
    typedef struct packed {
        logic signed [WORD_W-1:0] power_re;
        logic signed [WORD_W-1:0] power_im;
        logic                     overflow;
    } cip_out_t;

endpackage

/* hw/rtl/complex_integer_power_top.sv */
// ----------------------------------------------------------------------------
// complex_integer_power_top - complex base raised to an integer power
// Binary square-and-multiply over signed Q7.56 values, all products done on
// one shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; busy then stays
// high until the result has been shown. The result appears on result for one
// cycle with done high and must be captured in that cycle, since the block
// has no way to hold it. Every fixed point product runs through the phases
// of the shared 32x32 multiplier: operand capture, four partial products,
// accumulation, sign fix and saturation. Exponents of 0, 1 or negative need
// no squaring and go straight to done. Products truncate toward minus
// infinity, sums and products saturate, and overflow reports any saturation
// within that computation.
// ----------------------------------------------------------------------------
module complex_integer_power_top
    import cip_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cip_in_t  operand,
    output logic     busy,
    output logic     done,
    output cip_out_t result
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ADDSUB = 4'd1;
    localparam logic [3:0] ST_SQ_RE  = 4'd2;
    localparam logic [3:0] ST_SQ_IM  = 4'd3;
    localparam logic [3:0] ST_SQ_UPD = 4'd4;
    localparam logic [3:0] ST_MR1    = 4'd5;
    localparam logic [3:0] ST_MR2    = 4'd6;
    localparam logic [3:0] ST_MSUB   = 4'd7;
    localparam logic [3:0] ST_MI1    = 4'd8;
    localparam logic [3:0] ST_MI2    = 4'd9;
    localparam logic [3:0] ST_MUPD   = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    // Multiply phases
    localparam logic [2:0] MPH_CAP  = 3'd0;
    localparam logic [2:0] MPH_P00  = 3'd1;
    localparam logic [2:0] MPH_P01  = 3'd2;
    localparam logic [2:0] MPH_P10  = 3'd3;
    localparam logic [2:0] MPH_P11  = 3'd4;
    localparam logic [2:0] MPH_ACC  = 3'd5;
    localparam logic [2:0] MPH_NEG  = 3'd6;
    localparam logic [2:0] MPH_SAT  = 3'd7;

    localparam logic [EXP_W-1:0] EXP_MASK =
        (EXP_BITS >= EXP_W) ? {EXP_W{1'b1}} : EXP_W'((1 << EXP_BITS) - 1);

    // Saturating add: {flag, value}
    function automatic logic [WORD_W:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] s;
        s = a + b;
        if ((a[WORD_W-1] == b[WORD_W-1]) && (s[WORD_W-1] != a[WORD_W-1]))
            return {1'b1, a[WORD_W-1] ? SAT_MIN : SAT_MAX};
        return {1'b0, s};
    endfunction

    // Saturating subtract: {flag, value}
    function automatic logic [WORD_W:0] sat_sub(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] s;
        s = a - b;
        if ((a[WORD_W-1] != b[WORD_W-1]) && (s[WORD_W-1] != a[WORD_W-1]))
            return {1'b1, a[WORD_W-1] ? SAT_MIN : SAT_MAX};
        return {1'b0, s};
    endfunction

    // Control registers
    logic [3:0]            state_reg, state_next;
    logic [2:0]            mph_reg, mph_next;
    logic [EXP_W-2:0]      e_reg, e_next;
    logic                  ovf_reg, ovf_next;

    // Datapath registers
    logic [WORD_W-1:0]     xt_reg, xt_next;
    logic [WORD_W-1:0]     yt_reg, yt_next;
    logic [WORD_W-1:0]     rx_reg, rx_next;
    logic [WORD_W-1:0]     ry_reg, ry_next;
    logic [WORD_W-1:0]     ra_reg, ra_next;
    logic [WORD_W-1:0]     rb_reg, rb_next;
    logic [WORD_W-1:0]     rc_reg, rc_next;

    // Shared multiplier registers
    logic [WORD_W-1:0]     ma_reg, ma_next;
    logic [WORD_W-1:0]     mb_reg, mb_next;
    logic                  neg_reg, neg_next;
    logic [WORD_W-1:0]     pp_reg, pp_next;
    logic [PROD_W-1:0]     acc_reg, acc_next;

    // Combinational helpers
    logic [EXP_W-1:0]      e_eff;
    logic                  is_mul;
    logic [WORD_W-1:0]     op_a, op_b;
    logic [HALF_W-1:0]     mh_a, mh_b;
    logic [PROD_W-1:0]     acc_add;
    logic signed [PROD_W-1:0] shifted;
    logic                  mul_fits;
    logic [WORD_W-1:0]     mul_val;
    logic [WORD_W:0]       r1, r2;

    // Effective exponent: negative means zero, keep the low EXP_BITS bits
    assign e_eff = operand.exponent[EXP_W-1] ? '0 : (operand.exponent & EXP_MASK);

    assign is_mul = (state_reg == ST_SQ_RE) || (state_reg == ST_SQ_IM) ||
                    (state_reg == ST_MR1)   || (state_reg == ST_MR2)   ||
                    (state_reg == ST_MI1)   || (state_reg == ST_MI2);

    // Multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_SQ_RE: begin op_a = ra_reg; op_b = rb_reg; end
            ST_SQ_IM: begin op_a = xt_reg; op_b = yt_reg; end
            ST_MR1:   begin op_a = xt_reg; op_b = rx_reg; end
            ST_MR2:   begin op_a = yt_reg; op_b = ry_reg; end
            ST_MI1:   begin op_a = ry_reg; op_b = xt_reg; end
            ST_MI2:   begin op_a = yt_reg; op_b = rx_reg; end
            default:  begin op_a = xt_reg; op_b = yt_reg; end
        endcase
    end

    // Half-word select for the partial product of this phase
    assign mh_a = ((mph_reg == MPH_P10) || (mph_reg == MPH_P11)) ?
                  ma_reg[WORD_W-1:HALF_W] : ma_reg[HALF_W-1:0];
    assign mh_b = ((mph_reg == MPH_P01) || (mph_reg == MPH_P11)) ?
                  mb_reg[WORD_W-1:HALF_W] : mb_reg[HALF_W-1:0];

    // Alignment of the registered partial product being accumulated
    always_comb
    begin
        case (mph_reg)
            MPH_P01:          acc_add = {{WORD_W{1'b0}}, pp_reg};
            MPH_P10, MPH_P11: acc_add = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            MPH_ACC:          acc_add = {pp_reg, {WORD_W{1'b0}}};
            default:          acc_add = '0;
        endcase
    end

    // Scale back to Q format and saturate
    assign shifted  = $signed(acc_reg) >>> FRAC_BITS;
    assign mul_fits = (&shifted[PROD_W-1:WORD_W-1]) | ~(|shifted[PROD_W-1:WORD_W-1]);
    assign mul_val  = mul_fits ? shifted[WORD_W-1:0] :
                      (acc_reg[PROD_W-1] ? SAT_MIN : SAT_MAX);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next = state_reg;
        mph_next   = mph_reg;
        e_next     = e_reg;
        ovf_next   = ovf_reg;
        xt_next    = xt_reg;
        yt_next    = yt_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        rc_next    = rc_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        pp_next    = WORD_W'(mh_a) * WORD_W'(mh_b);
        acc_next   = acc_reg;
        r1         = '0;
        r2         = '0;

        // Shared multiply: phases of one fixed point product
        if (is_mul)
        begin
            mph_next = mph_reg + 3'd1;
            case (mph_reg)
                MPH_CAP:
                begin
                    ma_next  = op_a[WORD_W-1] ? (WORD_W'(0) - op_a) : op_a;
                    mb_next  = op_b[WORD_W-1] ? (WORD_W'(0) - op_b) : op_b;
                    neg_next = op_a[WORD_W-1] ^ op_b[WORD_W-1];
                    acc_next = '0;
                end
                MPH_P01, MPH_P10, MPH_P11, MPH_ACC:
                    acc_next = acc_reg + acc_add;
                MPH_NEG:
                    acc_next = neg_reg ? (~acc_reg + PROD_W'(1)) : acc_reg;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    xt_next  = operand.base_re;
                    yt_next  = operand.base_im;
                    rx_next  = e_eff[0] ? operand.base_re : Q_ONE;
                    ry_next  = e_eff[0] ? operand.base_im : '0;
                    e_next   = e_eff[EXP_W-1:1];
                    ovf_next = 1'b0;
                    state_next = (e_eff[EXP_W-1:1] != '0) ? ST_ADDSUB : ST_DONE;
                end
            end
            ST_ADDSUB:
            begin
                r1 = sat_add(xt_reg, yt_reg);
                r2 = sat_sub(xt_reg, yt_reg);
                ra_next  = r1[WORD_W-1:0];
                rb_next  = r2[WORD_W-1:0];
                ovf_next = ovf_reg | r1[WORD_W] | r2[WORD_W];
                state_next = ST_SQ_RE;
            end
            ST_SQ_RE, ST_SQ_IM, ST_MR1, ST_MR2, ST_MI1, ST_MI2:
            begin
                if (mph_reg == MPH_SAT)
                begin
                    ovf_next = ovf_reg | ~mul_fits;
                    unique case (state_reg)
                        ST_SQ_RE: begin ra_next = mul_val; state_next = ST_SQ_IM;  end
                        ST_SQ_IM: begin rb_next = mul_val; state_next = ST_SQ_UPD; end
                        ST_MR1:   begin ra_next = mul_val; state_next = ST_MR2;    end
                        ST_MR2:   begin rb_next = mul_val; state_next = ST_MSUB;   end
                        ST_MI1:   begin rb_next = mul_val; state_next = ST_MI2;    end
                        default:  begin rc_next = mul_val; state_next = ST_MUPD;   end
                    endcase
                end
            end
            ST_SQ_UPD:
            begin
                // New base: real part from the square, imaginary part 2xy
                r1 = sat_add(rb_reg, rb_reg);
                yt_next  = r1[WORD_W-1:0];
                xt_next  = ra_reg;
                ovf_next = ovf_reg | r1[WORD_W];
                if (e_reg[0])
                    state_next = ST_MR1;
                else
                begin
                    e_next     = e_reg >> 1;
                    state_next = (e_reg[EXP_W-2:1] != '0) ? ST_ADDSUB : ST_DONE;
                end
            end
            ST_MSUB:
            begin
                r1 = sat_sub(ra_reg, rb_reg);
                ra_next  = r1[WORD_W-1:0];
                ovf_next = ovf_reg | r1[WORD_W];
                state_next = ST_MI1;
            end
            ST_MUPD:
            begin
                r1 = sat_add(rb_reg, rc_reg);
                ry_next  = r1[WORD_W-1:0];
                rx_next  = ra_reg;
                ovf_next = ovf_reg | r1[WORD_W];
                e_next   = e_reg >> 1;
                state_next = (e_reg[EXP_W-2:1] != '0) ? ST_ADDSUB : ST_DONE;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mph_reg   <= MPH_CAP;
            e_reg     <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mph_reg   <= mph_next;
            e_reg     <= e_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        xt_reg  <= xt_next;
        yt_reg  <= yt_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
        rc_reg  <= rc_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    // Result beat
    assign busy            = (state_reg != ST_IDLE);
    assign done            = (state_reg == ST_DONE);
    assign result.power_re = rx_reg;
    assign result.power_im = ry_reg;
    assign result.overflow = ovf_reg;

endmodule

/* dv/tb_complex_integer_power_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_integer_power_top - self-checking bench for the complex power unit
// Drives command beats through the start/busy handshake with random gaps and
// checks every result beat against a bit-exact fixed point model of
// square-and-multiply. Directed cases cover trivial and negative exponents,
// extreme bases and saturation, followed by a long random run.
// ----------------------------------------------------------------------------
module tb_complex_integer_power_top;
    import cip_pkg::*;

    // Worst case latency: exponent 127 (six squarings, six multiplies)
    localparam int LAT_MAX = 313;
    localparam int RAND_BEATS = 1350;
    localparam logic [EXP_W-1:0] EXP_MASK = EXP_W'((1 << EXP_BITS) - 1);
    localparam logic [WORD_W-1:0] Q_MINUS_ONE = '0 - Q_ONE;
    localparam logic [WORD_W-1:0] Q_HALF = Q_ONE >> 1;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    cip_in_t  operand;
    logic     busy;
    logic     done;
    cip_out_t result;

    cip_out_t expected_powers[$];
    int       error_count = 0;
    logic     idle_enable = 1'b1;
    logic     sat_seen;

    complex_integer_power_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand (operand),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed point model
    // ------------------------------------------------------------------------

    // Saturating sum; overflow when both operands differ in sign from the sum
    function automatic logic [WORD_W-1:0] q_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] s;
        s = a + b;
        if (((a ^ s) & (b ^ s)) >> (WORD_W - 1))
        begin
            sat_seen = 1'b1;
            return a[WORD_W-1] ? SAT_MIN : SAT_MAX;
        end
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] q_sub(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] s;
        s = a - b;
        if (((a ^ b) & (a ^ s)) >> (WORD_W - 1))
        begin
            sat_seen = 1'b1;
            return a[WORD_W-1] ? SAT_MIN : SAT_MAX;
        end
        return s;
    endfunction

    // Full product, floor shift by the fraction width, saturate on sign of product
    function automatic logic [WORD_W-1:0] q_mul(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] sh;
        p  = $signed({{WORD_W{a[WORD_W-1]}}, a}) * $signed({{WORD_W{b[WORD_W-1]}}, b});
        sh = p >>> FRAC_BITS;
        if (sh[PROD_W-1:WORD_W-1] != {(WORD_W+1){sh[WORD_W-1]}})
        begin
            sat_seen = 1'b1;
            return p[PROD_W-1] ? SAT_MIN : SAT_MAX;
        end
        return sh[WORD_W-1:0];
    endfunction

    // Square-and-multiply over the exponent bits, LSB first
    function automatic cip_out_t predict_power(input cip_in_t cmd);
        logic [WORD_W-1:0] br, bi, ar, ai, t, u;
        logic [EXP_W-1:0]  e;
        cip_out_t          r;
        sat_seen = 1'b0;
        br = cmd.base_re;
        bi = cmd.base_im;
        e  = cmd.exponent;
        if (e[EXP_W-1])
            e = '0;
        e = e & EXP_MASK;
        if (e[0])
        begin
            ar = br;
            ai = bi;
        end
        else
        begin
            ar = Q_ONE;
            ai = '0;
        end
        e = e >> 1;
        while (e != 0)
        begin
            t  = q_mul(q_add(br, bi), q_sub(br, bi));
            u  = q_mul(br, bi);
            bi = q_add(u, u);
            br = t;
            if (e[0])
            begin
                t  = q_sub(q_mul(br, ar), q_mul(bi, ai));
                u  = q_add(q_mul(ai, br), q_mul(bi, ar));
                ai = u;
                ar = t;
            end
            e = e >> 1;
        end
        r.power_re = ar;
        r.power_im = ai;
        r.overflow = sat_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: done marks a single-cycle result beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cip_out_t exp_beat;
        if (rst_n && done)
        begin
            if (expected_powers.size() == 0)
            begin
                $error("unexpected result beat: re=%h im=%h ovf=%b",
                       result.power_re, result.power_im, result.overflow);
                error_count++;
            end
            else
            begin
                exp_beat = expected_powers.pop_front();
                if (result.power_re !== exp_beat.power_re)
                begin
                    $error("power_re: expected %h, actual %h",
                           exp_beat.power_re, result.power_re);
                    error_count++;
                end
                if (result.power_im !== exp_beat.power_im)
                begin
                    $error("power_im: expected %h, actual %h",
                           exp_beat.power_im, result.power_im);
                    error_count++;
                end
                if (result.overflow !== exp_beat.overflow)
                begin
                    $error("overflow: expected %b, actual %b",
                           exp_beat.overflow, result.overflow);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic cip_in_t make_cmd(input logic [WORD_W-1:0] re,
                                         input logic [WORD_W-1:0] im,
                                         input logic [EXP_W-1:0]  ex);
        cip_in_t c;
        c.base_re  = re;
        c.base_im  = im;
        c.exponent = ex;
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly values near the unit circle, some full range, some corner values
    function automatic logic [WORD_W-1:0] rand_part();
        logic signed [WORD_W-1:0] w;
        int unsigned              pick;
        pick = $urandom_range(0, 99);
        w = rand_word();
        if (pick < 60)
            w = w >>> $urandom_range(6, 9);
        else if (pick < 75)
            w = w >>> $urandom_range(1, 5);
        else if (pick < 90)
            w = w;
        else
        begin
            case ($urandom_range(0, 5))
                0: w = SAT_MIN;
                1: w = SAT_MAX;
                2: w = '0;
                3: w = Q_ONE;
                4: w = Q_MINUS_ONE;
                default: w = Q_HALF;
            endcase
        end
        return w;
    endfunction

    function automatic logic [EXP_W-1:0] rand_exponent();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return EXP_W'($urandom);
        else if (pick < 65)
            return EXP_W'($urandom_range(0, 127));
        else
            return EXP_W'($urandom_range(0, 15));
    endfunction

    // Send one command beat; returns after the accepting edge
    task automatic send_cmd(input cip_in_t cmd);
        int unsigned gap;
        gap = idle_enable ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        operand <= cmd;
        do
            @(posedge clk);
        while (busy);
        expected_powers.push_back(predict_power(cmd));
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_powers.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero, negative and unit exponents: no squaring at all
    task automatic test_trivial_exponents();
        send_cmd(make_cmd(rand_word(), rand_word(), 8'sd0));
        send_cmd(make_cmd(SAT_MIN, SAT_MIN, 8'sd0));
        send_cmd(make_cmd(SAT_MAX, SAT_MAX, -8'sd1));
        send_cmd(make_cmd(rand_word(), rand_word(), 8'h80));
        send_cmd(make_cmd(SAT_MAX, SAT_MIN, 8'sd1));
        send_cmd(make_cmd(SAT_MIN, SAT_MAX, 8'sd1));
        wait_results_drained();
    endtask

    // Bases at the range limits, and 2+i to the 127th, forcing saturation through the chain
    task automatic test_saturating_powers();
        send_cmd(make_cmd(SAT_MAX, SAT_MAX, 8'sd2));
        send_cmd(make_cmd(SAT_MIN, '0, 8'sd2));
        send_cmd(make_cmd(SAT_MIN, SAT_MIN, 8'sd3));
        send_cmd(make_cmd('0, SAT_MIN, 8'sd127));
        send_cmd(make_cmd(Q_ONE << 1, Q_ONE, 8'sd127));
        wait_results_drained();
    endtask

    // Powers with exact answers (units, zero, half-diagonal) and a random base to the highest exponent bit
    task automatic test_exact_powers();
        send_cmd(make_cmd(Q_ONE, '0, 8'sd127));
        send_cmd(make_cmd('0, Q_ONE, 8'sd4));
        send_cmd(make_cmd('0, Q_ONE, 8'sd5));
        send_cmd(make_cmd(Q_MINUS_ONE, '0, 8'sd127));
        send_cmd(make_cmd('0, '0, 8'sd127));
        send_cmd(make_cmd(Q_HALF, Q_HALF, 8'sd8));
        send_cmd(make_cmd(rand_word() >>> 7, rand_word() >>> 7, 8'sd64));
        wait_results_drained();
    endtask

    // Long random run; idling switched off in some stretches
    task automatic test_random_powers();
        for (int n = 0; n < RAND_BEATS; n++)
        begin
            if (n % 150 == 0)
                idle_enable = ($urandom_range(0, 2) != 0);
            send_cmd(make_cmd(rand_part(), rand_part(), rand_exponent()));
            if (n == RAND_BEATS / 2)
                wait_results_drained();
        end
        wait_results_drained();
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        operand = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_trivial_exponents();
        test_saturating_powers();
        test_exact_powers();
        test_random_powers();

        repeat (LAT_MAX + 10) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial
    begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
